### rtl/core/disjoint_interval_set_assert.svh
// ---------------------------------------------------------------------------
// Disjoint interval set assertion macros
// Shorthand for clocked implication checks with active-low reset gating.
// ---------------------------------------------------------------------------
`ifndef DISJOINT_INTERVAL_SET_ASSERT_SVH
`define DISJOINT_INTERVAL_SET_ASSERT_SVH

// same-cycle implication
`define DIS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DIS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/dis_pkg.sv
// ---------------------------------------------------------------------------
// dis_pkg
// Shared types and constants of the disjoint interval set.
// ---------------------------------------------------------------------------
package dis_pkg;

  localparam int COORD_W = 32;
  localparam int WIDE_W  = COORD_W + 1;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [WIDE_W-1:0]  wide_t;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_ERASE  = 3'd1;
  localparam logic [2:0] FN_COVER  = 3'd2;
  localparam logic [2:0] FN_FREE   = 3'd3;
  localparam logic [2:0] FN_SAME   = 3'd4;

  typedef struct packed {
    coord_t s;
    coord_t e;
  } ivl_t;

  // up to two intervals produced in one step, slot 0 first
  typedef struct packed {
    logic v0;
    logic v1;
    ivl_t i0;
    ivl_t i1;
  } emit_t;

  typedef struct packed {
    logic [2:0] func;
    coord_t     lo;
    coord_t     hi;
  } req_t;

  // sweep findings handed to the controller
  typedef struct packed {
    coord_t l;
    coord_t r;
    wide_t  merged;
    wide_t  removed;
    logic   cov;
    ivl_t   cov_ivl;
    logic   ff_hit;
    coord_t ff_end;
    logic   same;
  } sweep_res_t;

endpackage

### rtl/core/dis_if.sv
// ---------------------------------------------------------------------------
// dis_in_if / dis_out_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface dis_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] lo;
  logic [31:0] hi;
  modport source (output valid, func, lo, hi, input ready);
  modport sink   (input valid, func, lo, hi, output ready);
endinterface

interface dis_out_if #(parameter int CNT_W = 7);
  logic             valid;
  logic             ready;
  logic             bad_request;
  logic             overflow;
  logic [32:0]      amount;
  logic             covered;
  logic [31:0]      cover_lo;
  logic [31:0]      cover_hi;
  logic [32:0]      first_free;
  logic             same_run;
  logic [32:0]      total_points;
  logic [CNT_W-1:0] interval_count;
  modport source (output valid, bad_request, overflow, amount, covered, cover_lo, cover_hi,
                  first_free, same_run, total_points, interval_count, input ready);
  modport sink   (input valid, bad_request, overflow, amount, covered, cover_lo, cover_hi,
                  first_free, same_run, total_points, interval_count, output ready);
endinterface

### rtl/core/dis_cell.sv
// ---------------------------------------------------------------------------
// dis_cell
// One table slot plus one rebuild slot; table slot rotates to its neighbor.
// ---------------------------------------------------------------------------
module dis_cell #(
  parameter int IDX = 0,
  parameter int KW  = 8
) (
  input  logic           clk,
  input  logic           rot_en,
  input  dis_pkg::ivl_t  nbr_in,
  output dis_pkg::ivl_t  tbl_out,
  input  dis_pkg::emit_t emit,
  input  logic [KW-1:0]  wr_k,
  input  logic           commit
);
  import dis_pkg::*;

  localparam logic [KW-1:0] MY_IDX = KW'(IDX);

  ivl_t tbl_r, tbl_nxt;
  ivl_t bld_r, bld_nxt;

  always_comb begin
    tbl_nxt = tbl_r;
    if (commit) begin
      tbl_nxt = bld_r;
    end else if (rot_en) begin
      tbl_nxt = nbr_in;
    end
  end

  // rebuild slot takes the emission aimed at its position
  always_comb begin
    bld_nxt = bld_r;
    if (emit.v0 && wr_k == MY_IDX) begin
      bld_nxt = emit.i0;
    end else if (emit.v1 && (wr_k + 1'b1) == MY_IDX) begin
      bld_nxt = emit.i1;
    end
  end

  always_ff @(posedge clk) begin
    tbl_r <= tbl_nxt;
    bld_r <= bld_nxt;
  end

  assign tbl_out = tbl_r;

endmodule

### rtl/core/dis_sweep.sv
// ---------------------------------------------------------------------------
// dis_sweep
// Per-entry merge/split/lookup unit fed by the head of the cell chain.
// ---------------------------------------------------------------------------
module dis_sweep (
  input  logic                 clk,
  input  logic                 init,
  input  dis_pkg::req_t        init_req,
  input  dis_pkg::req_t        req,
  input  logic                 step_v,
  input  dis_pkg::ivl_t        cur,
  input  logic                 fin,
  output dis_pkg::emit_t       emit,
  output dis_pkg::sweep_res_t  res
);
  import dis_pkg::*;

  coord_t l_r, l_nxt, r_r, r_nxt;
  wide_t  merged_r, merged_nxt, removed_r, removed_nxt;
  logic   placed_r, placed_nxt;
  logic   cov_r, cov_nxt, ff_r, ff_nxt, same_r, same_nxt;
  ivl_t   cov_ivl_r, cov_ivl_nxt;
  coord_t ff_end_r, ff_end_nxt;

  wide_t  s_w, e_w, lo_w, hi_w, a_w, b_w;
  logic   has_lo, has_hi;

  assign s_w  = {1'b0, cur.s};
  assign e_w  = {1'b0, cur.e};
  assign lo_w = {1'b0, req.lo};
  assign hi_w = {1'b0, req.hi};
  assign a_w  = (cur.s > req.lo) ? s_w : lo_w;
  assign b_w  = (cur.e < req.hi) ? e_w : hi_w;
  assign has_lo = (cur.s <= req.lo) && (req.lo <= cur.e);
  assign has_hi = (cur.s <= req.hi) && (req.hi <= cur.e);

  always_comb begin
    emit        = '0;
    l_nxt       = l_r;
    r_nxt       = r_r;
    merged_nxt  = merged_r;
    removed_nxt = removed_r;
    placed_nxt  = placed_r;
    cov_nxt     = cov_r;
    cov_ivl_nxt = cov_ivl_r;
    ff_nxt      = ff_r;
    ff_end_nxt  = ff_end_r;
    same_nxt    = same_r;
    if (init) begin
      l_nxt       = init_req.lo;
      r_nxt       = init_req.hi;
      merged_nxt  = '0;
      removed_nxt = '0;
      placed_nxt  = 1'b0;
      cov_nxt     = 1'b0;
      ff_nxt      = 1'b0;
      same_nxt    = 1'b0;
    end else if (step_v) begin
      if (has_lo) begin
        ff_nxt     = 1'b1;
        ff_end_nxt = cur.e;
        if (req.hi <= cur.e) begin
          cov_nxt     = 1'b1;
          cov_ivl_nxt = cur;
        end
        if (has_hi) begin
          same_nxt = 1'b1;
        end
      end
      if (req.func == FN_INSERT) begin
        if (e_w + 1'b1 < lo_w) begin
          emit.v0 = 1'b1;
          emit.i0 = cur;
        end else if (s_w > hi_w + 1'b1) begin
          if (!placed_r) begin
            emit.v0    = 1'b1;
            emit.i0    = '{s: l_r, e: r_r};
            emit.v1    = 1'b1;
            emit.i1    = cur;
            placed_nxt = 1'b1;
          end else begin
            emit.v0 = 1'b1;
            emit.i0 = cur;
          end
        end else begin
          if (cur.s < l_r) l_nxt = cur.s;
          if (cur.e > r_r) r_nxt = cur.e;
          merged_nxt = merged_r + (e_w - s_w + 1'b1);
        end
      end else if (req.func == FN_ERASE) begin
        if (cur.e < req.lo || cur.s > req.hi) begin
          emit.v0 = 1'b1;
          emit.i0 = cur;
        end else begin
          removed_nxt = removed_r + (b_w - a_w + 1'b1);
          if (cur.s < req.lo) begin
            emit.v0 = 1'b1;
            emit.i0 = '{s: cur.s, e: req.lo - 1'b1};
            if (cur.e > req.hi) begin
              emit.v1 = 1'b1;
              emit.i1 = '{s: req.hi + 1'b1, e: cur.e};
            end
          end else if (cur.e > req.hi) begin
            emit.v0 = 1'b1;
            emit.i0 = '{s: req.hi + 1'b1, e: cur.e};
          end
        end
      end
    end else if (fin && req.func == FN_INSERT && !placed_r) begin
      emit.v0    = 1'b1;
      emit.i0    = '{s: l_r, e: r_r};
      placed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    merged_r  <= merged_nxt;
    removed_r <= removed_nxt;
    placed_r  <= placed_nxt;
    cov_r     <= cov_nxt;
    cov_ivl_r <= cov_ivl_nxt;
    ff_r      <= ff_nxt;
    ff_end_r  <= ff_end_nxt;
    same_r    <= same_nxt;
  end

  assign res = '{l: l_r, r: r_r, merged: merged_r, removed: removed_r, cov: cov_r,
                 cov_ivl: cov_ivl_r, ff_hit: ff_r, ff_end: ff_end_r, same: same_r};

endmodule

### rtl/core/disjoint_interval_set.sv
// ---------------------------------------------------------------------------
// disjoint_interval_set
// Sorted table of disjoint, non-adjacent closed intervals with merge/split.
// ---------------------------------------------------------------------------
// The table lives in a ring of MAX_INTERVALS cells that rotates once past a
// single sweep unit, one entry per cycle. The S_FIN state then closes an
// insert, and S_DONE commits and registers the result once the output
// register is free. The block then returns to idle; it takes no new request
// while one is in progress. A new request is accepted once the block is back
// in idle, which may happen while the previous result still waits in the
// output register. Insert and erase build the new table in the cells'
// rebuild slots and copy it over at commit; if the new table would exceed
// MAX_INTERVALS entries the table is left alone and overflow is flagged.
// Coordinates are 32 bits; amounts and totals are 33 bits.
// ---------------------------------------------------------------------------
`include "disjoint_interval_set_assert.svh"

module disjoint_interval_set #(
  parameter int MAX_INTERVALS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  dis_in_if.sink    in_ch,
  dis_out_if.source out_ch
);
  import dis_pkg::*;

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int KW    = $clog2(2 * MAX_INTERVALS + 3);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_INTERVALS - 1);
  localparam logic [KW-1:0]    K_MAX    = KW'(MAX_INTERVALS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_FIN  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  req_t             req_r, req_nxt, in_req;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  wide_t            total_r, total_nxt;

  logic accept, done_go, commit, bad, step_v, rot_en;
  emit_t      emit;
  sweep_res_t sres;
  ivl_t       cell_q [MAX_INTERVALS];
  wide_t      added;

  // output register
  logic             ov_r, ov_nxt;
  logic             o_bad_r, o_ovf_r, o_cov_r, o_same_r;
  wide_t            o_amt_r, o_ff_r, o_tot_r;
  coord_t           o_clo_r, o_chi_r;
  logic [CNT_W-1:0] o_cnt_r;
  logic             o_bad_nxt, o_ovf_nxt, o_cov_nxt, o_same_nxt;
  wide_t            o_amt_nxt, o_ff_nxt;
  coord_t           o_clo_nxt, o_chi_nxt;

  assign in_req   = '{func: in_ch.func, lo: in_ch.lo, hi: in_ch.hi};
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign done_go  = (state_r == S_DONE) && (!ov_r || out_ch.ready);
  assign rot_en   = (state_r == S_RUN);
  // only live table entries feed the sweep; the ring still turns a full lap
  assign step_v   = rot_en && ({1'b0, idx_r} < (IDX_W + 1)'(used_r));
  assign bad      = (req_r.func == FN_INSERT || req_r.func == FN_ERASE ||
                     req_r.func == FN_COVER) && (req_r.lo > req_r.hi);
  assign added    = ({1'b0, sres.r} - {1'b0, sres.l} + 1'b1) - sres.merged;

  // ---- ring of cells: cell 0 is the head seen by the sweep unit ----
  for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
    dis_cell #(.IDX(g), .KW(KW)) u_cell (
      .clk    (clk),
      .rot_en (rot_en),
      .nbr_in (cell_q[(g + 1) % MAX_INTERVALS]),
      .tbl_out(cell_q[g]),
      .emit   (emit),
      .wr_k   (k_r),
      .commit (commit)
    );
  end

  dis_sweep u_sweep (
    .clk     (clk),
    .init    (accept),
    .init_req(in_req),
    .req     (req_r),
    .step_v  (step_v),
    .cur     (cell_q[0]),
    .fin     (state_r == S_FIN),
    .emit    (emit),
    .res     (sres)
  );

  // ---- sequencing ----
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r + KW'(emit.v0) + KW'(emit.v1);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req;
          idx_nxt   = '0;
          k_nxt     = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: state_nxt = S_DONE;
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- commit and result formation ----
  always_comb begin
    commit     = 1'b0;
    used_nxt   = used_r;
    total_nxt  = total_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_bad_nxt  = bad;
    o_ovf_nxt  = 1'b0;
    o_amt_nxt  = '0;
    o_cov_nxt  = 1'b0;
    o_clo_nxt  = '0;
    o_chi_nxt  = '0;
    o_ff_nxt   = '0;
    o_same_nxt = 1'b0;
    if (done_go) begin
      ov_nxt = 1'b1;
      if (!bad) begin
        unique case (req_r.func)
          FN_INSERT, FN_ERASE: begin
            if (k_r <= K_MAX) begin
              commit    = 1'b1;
              used_nxt  = CNT_W'(k_r);
              o_amt_nxt = (req_r.func == FN_INSERT) ? added : sres.removed;
              total_nxt = (req_r.func == FN_INSERT) ? total_r + added
                                                    : total_r - sres.removed;
            end else begin
              o_ovf_nxt = 1'b1;
            end
          end
          FN_COVER: begin
            o_cov_nxt = sres.cov;
            o_clo_nxt = sres.cov ? sres.cov_ivl.s : '0;
            o_chi_nxt = sres.cov ? sres.cov_ivl.e : '0;
          end
          FN_FREE: begin
            o_ff_nxt = sres.ff_hit ? {1'b0, sres.ff_end} + 1'b1 : {1'b0, req_r.lo};
          end
          FN_SAME:  o_same_nxt = sres.same;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    if (done_go) begin
      o_bad_r  <= o_bad_nxt;
      o_ovf_r  <= o_ovf_nxt;
      o_amt_r  <= o_amt_nxt;
      o_cov_r  <= o_cov_nxt;
      o_clo_r  <= o_clo_nxt;
      o_chi_r  <= o_chi_nxt;
      o_ff_r   <= o_ff_nxt;
      o_same_r <= o_same_nxt;
      o_tot_r  <= total_nxt;
      o_cnt_r  <= used_nxt;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.bad_request    = o_bad_r;
  assign out_ch.overflow       = o_ovf_r;
  assign out_ch.amount         = o_amt_r;
  assign out_ch.covered        = o_cov_r;
  assign out_ch.cover_lo       = o_clo_r;
  assign out_ch.cover_hi       = o_chi_r;
  assign out_ch.first_free     = o_ff_r;
  assign out_ch.same_run       = o_same_r;
  assign out_ch.total_points   = o_tot_r;
  assign out_ch.interval_count = o_cnt_r;

  // ---- checks ----
  `DIS_ASSERT_IMP(a_used_cap, clk, rst_n, 1'b1, used_r <= CNT_W'(MAX_INTERVALS), "table over capacity")
  `DIS_ASSERT_IMP(a_ovf_zero, clk, rst_n, ov_r && o_ovf_r, o_amt_r == '0 && !o_bad_r, "overflow with amount")
  `DIS_ASSERT_NXT(a_k_mono, clk, rst_n, state_r == S_RUN, k_r >= $past(k_r), "rebuild count went back")
  `DIS_ASSERT_NXT(a_commit_idle, clk, rst_n, commit, state_r == S_IDLE && ov_r, "commit without result")

endmodule
